### hw/rtl/vards_pkg.sv
package vards_pkg;

   localparam int MAX_WIDTH_DEFAULT = 2048;

   localparam int PIXEL_WIDTH       = 32;
   localparam int VALUE_WIDTH       = 32;
   localparam int COLUMN_WIDTH      = 11;
   localparam int SCALE_WIDTH       = 13;
   localparam int WEIGHT_WIDTH      = 14;
   localparam int ROW_WIDTH_WIDTH   = 12;
   localparam int LAST_WEIGHT_WIDTH = 16;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 14;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SCALE_FROM     = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SCALE_TO       = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INITIAL_WEIGHT = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROW_WIDTH      = 2'd3;

   // Reset values of the configuration registers.
   localparam logic [SCALE_WIDTH-1:0]     SCALE_FROM_RESET     = 13'd2;
   localparam logic [SCALE_WIDTH-1:0]     SCALE_TO_RESET       = 13'd1;
   localparam logic [WEIGHT_WIDTH-1:0]    INITIAL_WEIGHT_RESET = 14'd1;
   localparam logic [ROW_WIDTH_WIDTH-1:0] ROW_WIDTH_RESET      = 12'd2048;

   // What an input row does with its pixels.
   typedef enum logic [1:0] {
      ROLE_LEADING,
      ROLE_MIDDLE,
      ROLE_CLOSING
   } role_type;

   // Per-pixel operation handed from the row control to the datapath.
   typedef struct packed {
      role_type                       role;
      logic                           last;
      logic                           have_sum;
      logic                           have_carry;
      logic                           weight_nonzero;
      logic [SCALE_WIDTH-1:0]         carry_weight;
      logic [LAST_WEIGHT_WIDTH-1:0]   last_weight;
      logic [SCALE_WIDTH-1:0]         scale_to;
   } row_op_type;

endpackage

### hw/rtl/vards_ram.sv
module vards_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // A read at the address being written returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/vards_ctrl.sv
module vards_ctrl #(
   parameter int MAX_WIDTH = vards_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       csr_valid,
   input  logic [vards_pkg::CSR_INDEX_WIDTH-1:0]      csr_index,
   input  logic [vards_pkg::CSR_DATA_WIDTH-1:0]       csr_data,
   input  logic                                       accept,
   output logic [(MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1)-1:0] column,
   output vards_pkg::row_op_type                      op
);

   import vards_pkg::*;

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam logic [WEIGHT_WIDTH-1:0] MaxWidthW = WEIGHT_WIDTH'(MAX_WIDTH);

   logic [SCALE_WIDTH-1:0]         scale_from_ff, scale_from_in;
   logic [SCALE_WIDTH-1:0]         scale_to_ff, scale_to_in;
   logic [ROW_WIDTH_WIDTH-1:0]     row_width_ff, row_width_in;
   logic signed [WEIGHT_WIDTH-1:0] weight_left_ff, weight_left_in;
   logic [SCALE_WIDTH-1:0]         carry_weight_ff, carry_weight_in;
   logic                           have_carry_ff, have_carry_in;
   logic                           have_sum_ff, have_sum_in;
   logic [CW-1:0]                  column_count_ff, column_count_in;

   logic [WEIGHT_WIDTH-1:0] row_width_ext;
   logic [WEIGHT_WIDTH-1:0] width_use;
   logic [WEIGHT_WIDTH-1:0] column_next;
   logic                    last;
   logic [WEIGHT_WIDTH-1:0] step_add;
   logic [WEIGHT_WIDTH-1:0] weight_neg;
   role_type                role;

   always_comb begin
      row_width_ext = {{(WEIGHT_WIDTH-ROW_WIDTH_WIDTH){1'b0}}, row_width_ff};
      if (row_width_ext == '0) begin
         width_use = WEIGHT_WIDTH'(1);
      end else if (row_width_ext > MaxWidthW) begin
         width_use = MaxWidthW;
      end else begin
         width_use = row_width_ext;
      end

      column_next = WEIGHT_WIDTH'(column_count_ff) + WEIGHT_WIDTH'(1);
      last        = (column_next >= width_use);

      step_add   = {1'b0, scale_from_ff} - {1'b0, scale_to_ff};
      weight_neg = '0 - weight_left_ff;

      if (!have_carry_ff && weight_left_ff[WEIGHT_WIDTH-1]) begin
         role = ROLE_LEADING;
      end else if (!weight_left_ff[WEIGHT_WIDTH-1] && (weight_left_ff != '0)) begin
         role = ROLE_MIDDLE;
      end else begin
         role = ROLE_CLOSING;
      end
   end

   always_comb begin
      scale_from_in   = scale_from_ff;
      scale_to_in     = scale_to_ff;
      row_width_in    = row_width_ff;
      weight_left_in  = weight_left_ff;
      carry_weight_in = carry_weight_ff;
      have_carry_in   = have_carry_ff;
      have_sum_in     = have_sum_ff;
      column_count_in = column_count_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_SCALE_FROM: begin
               scale_from_in = csr_data[SCALE_WIDTH-1:0];
            end
            CSR_SCALE_TO: begin
               scale_to_in = csr_data[SCALE_WIDTH-1:0];
            end
            CSR_INITIAL_WEIGHT: begin
               // Loading the weight starts a new frame.
               weight_left_in  = csr_data[WEIGHT_WIDTH-1:0];
               carry_weight_in = '0;
               have_carry_in   = 1'b0;
               have_sum_in     = 1'b0;
               column_count_in = '0;
            end
            CSR_ROW_WIDTH: begin
               row_width_in = csr_data[ROW_WIDTH_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end else if (accept) begin
         column_count_in = last ? '0 : column_next[CW-1:0];
         if (last) begin
            case (role)
               ROLE_LEADING: begin
                  carry_weight_in = weight_neg[SCALE_WIDTH-1:0];
                  have_carry_in   = 1'b1;
                  weight_left_in  = weight_left_ff + step_add;
               end
               ROLE_MIDDLE: begin
                  have_sum_in    = 1'b1;
                  weight_left_in = weight_left_ff - {1'b0, scale_to_ff};
               end
               default: begin
                  have_sum_in = 1'b0;
                  if (weight_left_ff != '0) begin
                     carry_weight_in = weight_neg[SCALE_WIDTH-1:0];
                     have_carry_in   = 1'b1;
                     weight_left_in  = weight_left_ff + step_add;
                  end else begin
                     carry_weight_in = '0;
                     have_carry_in   = 1'b0;
                     weight_left_in  = step_add;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_from_ff   <= SCALE_FROM_RESET;
         scale_to_ff     <= SCALE_TO_RESET;
         row_width_ff    <= ROW_WIDTH_RESET;
         weight_left_ff  <= INITIAL_WEIGHT_RESET;
         carry_weight_ff <= '0;
         have_carry_ff   <= 1'b0;
         have_sum_ff     <= 1'b0;
         column_count_ff <= '0;
      end else begin
         scale_from_ff   <= scale_from_in;
         scale_to_ff     <= scale_to_in;
         row_width_ff    <= row_width_in;
         weight_left_ff  <= weight_left_in;
         carry_weight_ff <= carry_weight_in;
         have_carry_ff   <= have_carry_in;
         have_sum_ff     <= have_sum_in;
         column_count_ff <= column_count_in;
      end
   end

   assign column = column_count_ff;

   always_comb begin
      op.role           = role;
      op.last           = last;
      op.have_sum       = have_sum_ff;
      op.have_carry     = have_carry_ff;
      op.weight_nonzero = (weight_left_ff != '0);
      op.carry_weight   = carry_weight_ff;
      op.last_weight    = {{(LAST_WEIGHT_WIDTH-WEIGHT_WIDTH){weight_left_ff[WEIGHT_WIDTH-1]}},
                           weight_left_ff}
                          + {{(LAST_WEIGHT_WIDTH-SCALE_WIDTH){1'b0}}, scale_to_ff};
      op.scale_to       = scale_to_ff;
   end

endmodule

### hw/rtl/vards_datapath.sv
module vards_datapath #(
   parameter int MAX_WIDTH = vards_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_ready,
   input  logic [vards_pkg::PIXEL_WIDTH-1:0]          req_pixel,
   input  vards_pkg::row_op_type                      op,
   input  logic [(MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1)-1:0] column,
   output logic                                       accept,
   output logic                                       rsp_valid,
   input  logic                                       rsp_ready,
   output logic [vards_pkg::VALUE_WIDTH-1:0]          rsp_value,
   output logic [vards_pkg::COLUMN_WIDTH-1:0]         rsp_column,
   output logic                                       rsp_row_end
);

   import vards_pkg::*;

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   // Stage one: the accepted pixel with the store entries being read.
   logic                   s1_valid_ff, s1_valid_in;
   row_op_type             s1_op_ff;
   logic [CW-1:0]          s1_column_ff;
   logic [PIXEL_WIDTH-1:0] s1_pixel_ff;
   logic                   sum_fwd_hit_ff, carry_fwd_hit_ff;
   logic [VALUE_WIDTH-1:0] sum_fwd_data_ff, carry_fwd_data_ff;

   // Stage two: the output register, holding the three weighted terms.
   logic                    s2_valid_ff, s2_valid_in;
   logic [VALUE_WIDTH-1:0]  s2_pixel_term_ff, s2_carry_term_ff, s2_sum_term_ff;
   logic [COLUMN_WIDTH-1:0] s2_column_ff;
   logic                    s2_row_end_ff;

   logic                   s2_free;
   logic                   s1_emit;
   logic                   s1_advance;
   logic                   sum_we, carry_we;
   logic [VALUE_WIDTH-1:0] sum_q, carry_q;
   logic [VALUE_WIDTH-1:0] sum_rd, carry_rd;
   logic [VALUE_WIDTH-1:0] sum_wdata;
   logic [VALUE_WIDTH-1:0] pixel_term, carry_term, sum_term;
   logic [31:0]            column_ext;

   always_comb begin
      s2_free    = !s2_valid_ff || rsp_ready;
      s1_emit    = (s1_op_ff.role == ROLE_CLOSING);
      s1_advance = s1_valid_ff && (!s1_emit || s2_free);
      req_ready  = !s1_valid_ff || s1_advance;
      accept     = req_valid && req_ready;

      // The item ahead writes at the same edge this one reads, so its data is forwarded.
      sum_rd   = sum_fwd_hit_ff ? sum_fwd_data_ff : sum_q;
      carry_rd = carry_fwd_hit_ff ? carry_fwd_data_ff : carry_q;

      sum_wdata = s1_op_ff.have_sum ? (sum_rd + s1_pixel_ff) : s1_pixel_ff;
      sum_we    = s1_advance && (s1_op_ff.role == ROLE_MIDDLE);
      carry_we  = s1_advance && ((s1_op_ff.role == ROLE_LEADING) ||
                                 (s1_emit && s1_op_ff.weight_nonzero));

      pixel_term = s1_pixel_ff *
                   {{(VALUE_WIDTH-LAST_WEIGHT_WIDTH){s1_op_ff.last_weight[LAST_WEIGHT_WIDTH-1]}},
                    s1_op_ff.last_weight};
      carry_term = s1_op_ff.have_carry ?
                   carry_rd * {{(VALUE_WIDTH-SCALE_WIDTH){1'b0}}, s1_op_ff.carry_weight} : '0;
      sum_term   = s1_op_ff.have_sum ?
                   sum_rd * {{(VALUE_WIDTH-SCALE_WIDTH){1'b0}}, s1_op_ff.scale_to} : '0;

      column_ext = 32'(s1_column_ff);

      s1_valid_in = accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);
      if (s1_advance && s1_emit) begin
         s2_valid_in = 1'b1;
      end else if (rsp_ready) begin
         s2_valid_in = 1'b0;
      end else begin
         s2_valid_in = s2_valid_ff;
      end
   end

   vards_ram #(
      .WIDTH(VALUE_WIDTH),
      .DEPTH(MAX_WIDTH)
   ) u_sum_store (
      .clock  (clock),
      .wr_en  (sum_we),
      .wr_addr(s1_column_ff),
      .wr_data(sum_wdata),
      .rd_en  (accept),
      .rd_addr(column),
      .rd_data(sum_q)
   );

   vards_ram #(
      .WIDTH(VALUE_WIDTH),
      .DEPTH(MAX_WIDTH)
   ) u_carry_store (
      .clock  (clock),
      .wr_en  (carry_we),
      .wr_addr(s1_column_ff),
      .wr_data(s1_pixel_ff),
      .rd_en  (accept),
      .rd_addr(column),
      .rd_data(carry_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff          <= op;
         s1_column_ff      <= column;
         s1_pixel_ff       <= req_pixel;
         sum_fwd_hit_ff    <= sum_we && (s1_column_ff == column);
         sum_fwd_data_ff   <= sum_wdata;
         carry_fwd_hit_ff  <= carry_we && (s1_column_ff == column);
         carry_fwd_data_ff <= s1_pixel_ff;
      end
      if (s1_advance && s1_emit) begin
         s2_pixel_term_ff <= pixel_term;
         s2_carry_term_ff <= carry_term;
         s2_sum_term_ff   <= sum_term;
         s2_column_ff     <= column_ext[COLUMN_WIDTH-1:0];
         s2_row_end_ff    <= s1_op_ff.last;
      end
   end

   assign rsp_valid   = s2_valid_ff;
   assign rsp_value   = s2_pixel_term_ff + s2_carry_term_ff + s2_sum_term_ff;
   assign rsp_column  = s2_column_ff;
   assign rsp_row_end = s2_row_end_ff;

endmodule

### hw/rtl/vertical_area_row_downscaler_unit.sv
// Each store has one read and one write port, used once per pixel. A result is registered in
// stage one and then in the output register. One pixel per cycle unless the output side stalls.
// Reset (synchronous, active high) restores the configuration defaults and the weight
// counter, and clears the carry and sum flags, the column counter and all pipeline valids.
// The sum and carry stores are not cleared and are not needed until written.
module vertical_area_row_downscaler_unit #(
   parameter int MAX_WIDTH = vards_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [vards_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [vards_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [vards_pkg::PIXEL_WIDTH-1:0]     req_pixel,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [vards_pkg::VALUE_WIDTH-1:0]     rsp_value,
   output logic [vards_pkg::COLUMN_WIDTH-1:0]    rsp_column,
   output logic                                  rsp_row_end
);

   import vards_pkg::*;

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   // The row control decides, from the signed weight counter, whether the current row is
   // a leading row (kept as the weighted carry row), a middle row (accumulated into the
   // per-column sum) or a closing row (which produces one output row). It updates its
   // state on every accepted transaction, so the next pixel sees the new state at once.
   row_op_type    op;
   logic [CW-1:0] column;
   logic          accept;

   // Configuration writes are always taken; the user must issue them only while the block is idle.
   assign csr_ready = 1'b1;

   vards_ctrl #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .csr_valid(csr_valid),
      .csr_index(csr_index),
      .csr_data (csr_data),
      .accept   (accept),
      .column   (column),
      .op       (op)
   );

   // The datapath reads both stores at the pixel's column when the transaction is
   // accepted, forms the closing-row weighted terms in stage one while writing the
   // updated sum or carry entry back, and holds the result in the output register.
   // A waiting result stops new pixels from entering only while stage one holds a closing-row pixel.
   vards_datapath #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_pixel  (req_pixel),
      .op         (op),
      .column     (column),
      .accept     (accept),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_value  (rsp_value),
      .rsp_column (rsp_column),
      .rsp_row_end(rsp_row_end)
   );

endmodule

### hw/rtl/vards_checker.sv
module vards_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [vards_pkg::VALUE_WIDTH-1:0]  rsp_value,
   input logic [vards_pkg::COLUMN_WIDTH-1:0] rsp_column,
   input logic                               rsp_row_end
);

   // A pending result transaction stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result transaction dropped before it was taken");

   // A stalled result keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_value) && $stable(rsp_column) &&
                                  $stable(rsp_row_end))
      else $error("result payload changed while stalled");

   // The input side only stalls when the output register is full and blocked.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled while the output side could move");

   // A fresh result follows an accepted input transaction.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result appeared without a matching input transaction");

endmodule

bind vertical_area_row_downscaler_unit vards_checker u_checker (.*);
